[design/glyph_to_rect_rasterizer_assert.svh]
// Assertion macros for the glyph rasterizer.
// Used by the top level; no other dependencies.
`ifndef GLYPH_TO_RECT_RASTERIZER_ASSERT_SVH
`define GLYPH_TO_RECT_RASTERIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define G2R_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define G2R_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define G2R_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define G2R_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[design/g2r_pkg.sv]
// Shared constants, types and the 5x7 font ROM for the glyph rasterizer.
// No dependencies.
`default_nettype none
package g2r_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;
  localparam int GLYPH_COLS    = 5;
  localparam int GLYPH_ROWS    = 7;
  localparam int COORD_W       = 10;
  localparam int EDGE_W        = 11;

  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd127;
  localparam logic [7:0] CHAR_SUBST = 8'h3F;

  // Entry bytes in column order 0..4, column k at bits [8*(4-k) +: 8], bit 0 top row
  localparam logic [39:0] GLYPH_ROM [96] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
  };

  // One classified character, ready for the back end
  typedef struct packed {
    logic [8:0]  x;
    logic [8:0]  y;
    logic [3:0]  s;        // effective scale, never zero
    logic [6:0]  tall;     // 7 * s, height of the spacing column
    logic [15:0] fg;
    logic [15:0] bg;
    logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph;
    logic [2:0]  max_col;  // last visible glyph column
    logic [2:0]  max_row;  // last visible glyph row
    logic        spc_vis;  // spacing column is on screen
  } desc_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

[design/glyph_to_rect_rasterizer.sv]
// Top level of the 5x7 glyph rasterizer: front end, queue, back end.
// Depends on g2r_pkg, g2r_front, g2r_queue, g2r_back and the assert header.
//
// Usage:
//   Drive x_pos, y_pos, char_code, fg_colour, bg_colour and scale with start
//   high; the request transfers at a clock edge where busy is low. busy is
//   high while the two-entry request queue is full.
//   Each clipped rectangle appears for one cycle with rect_valid high;
//   last_rect marks the final one of a character. Requests that land fully
//   off screen give no rectangles at all.
//   The first rectangle is registered out once the queued request has been
//   loaded into the back end. Throughput: the back end emits one rectangle
//   per cycle, so a character gives (visible columns * visible rows)
//   rectangles plus one for the spacing column when it is on screen, 36 at
//   most; the back end's cell walker sets this count. When the next request
//   is already queued, its first rectangle follows in the cycle after the previous one's last.
//   The receiver cannot stall; every strobed rectangle is taken.
//   Reset (rst, synchronous) empties the queue and stops the walker.
`default_nettype none
`include "glyph_to_rect_rasterizer_assert.svh"
module glyph_to_rect_rasterizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [8:0]  x_pos,
  input  wire logic [8:0]  y_pos,
  input  wire logic [7:0]  char_code,
  input  wire logic [15:0] fg_colour,
  input  wire logic [15:0] bg_colour,
  input  wire logic [3:0]  scale,
  output logic             rect_valid,
  output logic [7:0]       rect_x0,
  output logic [8:0]       rect_y0,
  output logic [7:0]       rect_x1,
  output logic [8:0]       rect_y1,
  output logic [15:0]      fill_colour,
  output logic             last_rect
);

  g2r_pkg::desc_t     front_desc;
  g2r_pkg::desc_t     q_desc;
  g2r_pkg::q_status_t q_status;
  logic               keep;
  logic               push;
  logic               pop;

  // Classify the request
  g2r_front u_front (
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .char_code (char_code),
    .fg_colour (fg_colour),
    .bg_colour (bg_colour),
    .scale     (scale),
    .desc      (front_desc),
    .keep      (keep)
  );

  // Queue only requests that leave something on screen
  assign busy = q_status.full;
  assign push = start && !busy && keep;

  g2r_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_desc  (front_desc),
    .pop      (pop),
    .rd_desc  (q_desc),
    .status   (q_status)
  );

  g2r_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_desc      (q_desc),
    .q_status    (q_status),
    .pop         (pop),
    .rect_valid  (rect_valid),
    .rect_x0     (rect_x0),
    .rect_y0     (rect_y0),
    .rect_x1     (rect_x1),
    .rect_y1     (rect_y1),
    .fill_colour (fill_colour),
    .last_rect   (last_rect)
  );

  // Rectangles are ordered and clipped to the screen
  `G2R_ASSERT_IMPL(a_rect_order, clk, rst, rect_valid, (rect_x0 <= rect_x1) && (rect_y0 <= rect_y1), "rectangle corners out of order")
  `G2R_ASSERT_IMPL(a_rect_clip, clk, rst, rect_valid, (rect_x1 <= 8'(g2r_pkg::SCREEN_WIDTH - 1)) && (rect_y1 <= 9'(g2r_pkg::SCREEN_HEIGHT - 1)), "rectangle outside screen")
  // A queued request is visible to the back end in the next cycle
  `G2R_ASSERT_NEXT(a_push_seen, clk, rst, push, q_status.valid, "queued request lost")
  // The back end only pulls from a non-empty queue
  `G2R_ASSERT_IMPL(a_pop_valid, clk, rst, pop, q_status.valid, "pop from empty queue")

endmodule
`default_nettype wire

[design/g2r_front.sv]
// Front end: resolves code and scale, reads the font ROM and works out
// which cells land on screen. Depends on g2r_pkg.
`default_nettype none
module g2r_front (
  input  wire logic [8:0]     x_pos,
  input  wire logic [8:0]     y_pos,
  input  wire logic [7:0]     char_code,
  input  wire logic [15:0]    fg_colour,
  input  wire logic [15:0]    bg_colour,
  input  wire logic [3:0]     scale,
  output g2r_pkg::desc_t      desc,
  output logic                keep
);

  logic [6:0]  rom_idx;
  logic [39:0] rom_word;
  logic [3:0]  s_eff;
  logic [g2r_pkg::GLYPH_COLS:0]   col_vis;
  logic [g2r_pkg::GLYPH_ROWS-1:0] row_vis;

  // Substitute out-of-range codes and zero scale
  always_comb begin
    if (char_code < g2r_pkg::CHAR_FIRST || char_code > g2r_pkg::CHAR_LAST) begin
      rom_idx = 7'(g2r_pkg::CHAR_SUBST - g2r_pkg::CHAR_FIRST);
    end else begin
      rom_idx = 7'(char_code - g2r_pkg::CHAR_FIRST);
    end
    s_eff    = (scale == 4'd0) ? 4'd1 : scale;
    rom_word = g2r_pkg::GLYPH_ROM[rom_idx];
  end

  // Check the left edge of every column and the top edge of every row
  always_comb begin
    for (int k = 0; k <= g2r_pkg::GLYPH_COLS; k++) begin
      col_vis[k] = (g2r_pkg::COORD_W'(x_pos) + g2r_pkg::COORD_W'(k) * g2r_pkg::COORD_W'(s_eff))
                   < g2r_pkg::COORD_W'(g2r_pkg::SCREEN_WIDTH);
    end
    for (int k = 0; k < g2r_pkg::GLYPH_ROWS; k++) begin
      row_vis[k] = (g2r_pkg::COORD_W'(y_pos) + g2r_pkg::COORD_W'(k) * g2r_pkg::COORD_W'(s_eff))
                   < g2r_pkg::COORD_W'(g2r_pkg::SCREEN_HEIGHT);
    end
  end

  // Build the descriptor; edges only grow, so visible counts give the limits
  always_comb begin
    desc.x    = x_pos;
    desc.y    = y_pos;
    desc.s    = s_eff;
    desc.tall = 7'(s_eff) * 7'(g2r_pkg::GLYPH_ROWS);
    desc.fg   = fg_colour;
    desc.bg   = bg_colour;
    for (int c = 0; c < g2r_pkg::GLYPH_COLS; c++) begin
      for (int r = 0; r < g2r_pkg::GLYPH_ROWS; r++) begin
        desc.glyph[c][r] = rom_word[8 * (g2r_pkg::GLYPH_COLS - 1 - c) + r];
      end
    end
    desc.max_col = 3'($countones(col_vis[g2r_pkg::GLYPH_COLS-1:0])) - 3'd1;
    desc.max_row = 3'($countones(row_vis)) - 3'd1;
    desc.spc_vis = col_vis[g2r_pkg::GLYPH_COLS] & row_vis[0];
    keep         = col_vis[0] & row_vis[0];
  end

endmodule
`default_nettype wire

[design/g2r_queue.sv]
// Two-entry descriptor queue between front and back end.
// Depends on g2r_pkg.
`default_nettype none
module g2r_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire g2r_pkg::desc_t wr_desc,
  input  wire logic           pop,
  output g2r_pkg::desc_t      rd_desc,
  output g2r_pkg::q_status_t  status
);

  g2r_pkg::desc_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  // Store an entry on each push transfer
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_desc;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign rd_desc      = mem[rptr];
  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);

endmodule
`default_nettype wire

[design/g2r_back.sv]
// Back end: walks the visible cells of one character and the spacing
// column, one clipped rectangle per cycle. Depends on g2r_pkg.
`default_nettype none
module g2r_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire g2r_pkg::desc_t     q_desc,
  input  wire g2r_pkg::q_status_t q_status,
  output logic                    pop,
  output logic                    rect_valid,
  output logic [7:0]              rect_x0,
  output logic [8:0]              rect_y0,
  output logic [7:0]              rect_x1,
  output logic [8:0]              rect_y1,
  output logic [15:0]             fill_colour,
  output logic                    last_rect
);

  g2r_pkg::desc_t cur;
  logic        active;
  logic        spc_phase;
  logic [2:0]  col;
  logic [2:0]  row;
  logic [g2r_pkg::COORD_W-1:0] left;
  logic [g2r_pkg::COORD_W-1:0] top;

  logic        last_cell;
  logic        finishing;
  logic [6:0]  height;
  logic [g2r_pkg::EDGE_W-1:0] right_raw;
  logic [g2r_pkg::EDGE_W-1:0] bottom_raw;
  logic [g2r_pkg::EDGE_W-1:0] right_clip;
  logic [g2r_pkg::EDGE_W-1:0] bottom_clip;
  logic [15:0] colour;

  // Decide whether this rectangle ends the character
  always_comb begin
    last_cell = (col == cur.max_col) && (row == cur.max_row);
    finishing = active && (spc_phase || (last_cell && !cur.spc_vis));
    pop       = q_status.valid && (!active || finishing);
  end

  // Form and clip the current rectangle
  always_comb begin
    height     = spc_phase ? cur.tall : 7'(cur.s);
    right_raw  = g2r_pkg::EDGE_W'(left) + g2r_pkg::EDGE_W'(cur.s) - g2r_pkg::EDGE_W'(1);
    bottom_raw = g2r_pkg::EDGE_W'(top) + g2r_pkg::EDGE_W'(height) - g2r_pkg::EDGE_W'(1);
    if (right_raw > g2r_pkg::EDGE_W'(g2r_pkg::SCREEN_WIDTH - 1)) begin
      right_clip = g2r_pkg::EDGE_W'(g2r_pkg::SCREEN_WIDTH - 1);
    end else begin
      right_clip = right_raw;
    end
    if (bottom_raw > g2r_pkg::EDGE_W'(g2r_pkg::SCREEN_HEIGHT - 1)) begin
      bottom_clip = g2r_pkg::EDGE_W'(g2r_pkg::SCREEN_HEIGHT - 1);
    end else begin
      bottom_clip = bottom_raw;
    end
    if (!spc_phase && cur.glyph[col][row]) begin
      colour = cur.fg;
    end else begin
      colour = cur.bg;
    end
  end

  // Load the next character or step through cells
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      spc_phase <= 1'b0;
    end else if (!active || finishing) begin
      active    <= q_status.valid;
      spc_phase <= 1'b0;
    end else if (last_cell) begin
      spc_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= q_desc;
      col  <= 3'd0;
      row  <= 3'd0;
      left <= g2r_pkg::COORD_W'(q_desc.x);
      top  <= g2r_pkg::COORD_W'(q_desc.y);
    end else if (active && !finishing) begin
      if (row == cur.max_row) begin
        col  <= col + 3'd1;
        row  <= 3'd0;
        left <= left + g2r_pkg::COORD_W'(cur.s);
        top  <= g2r_pkg::COORD_W'(cur.y);
      end else begin
        row <= row + 3'd1;
        top <= top + g2r_pkg::COORD_W'(cur.s);
      end
    end
  end

  // Register the result; the strobe lasts one cycle per rectangle
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_valid <= 1'b0;
    end else begin
      rect_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    rect_x0     <= 8'(left);
    rect_y0     <= 9'(top);
    rect_x1     <= 8'(right_clip);
    rect_y1     <= 9'(bottom_clip);
    fill_colour <= colour;
    last_rect   <= finishing;
  end

endmodule
`default_nettype wire
